// ===== design/fba_pkg.sv =====
// Shared types, constants and helpers for the frame bitmap allocator.
// Depends on nothing; every other file in the block imports it.
package fba_pkg;

   localparam int MAX_FRAMES_DEFAULT = 32768;
   localparam int WORD_BITS          = 32;
   localparam int FRAME_NUMBER_W     = 15;
   localparam int FRAME_COUNT_W      = 16;
   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 16'd32768;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_COUNT_ADDR = 2'd0;

   typedef enum logic [1:0] {
      OP_MARK_USED = 2'd0,
      OP_MARK_FREE = 2'd1,
      OP_TEST      = 2'd2,
      OP_FIND      = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic [FRAME_NUMBER_W-1:0] frame_number;
   } req_type;

   typedef struct packed {
      logic                     frame_used;
      logic [FRAME_COUNT_W-1:0] found_frame;
      logic                     none_free;
      logic                     bad_frame;
   } rsp_type;

   // Index of the lowest clear bit; only meaningful when some bit is clear.
   function automatic logic [4:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [4:0] idx;
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) begin
            idx = 5'(b);
         end
      end
      return idx;
   endfunction

endpackage

// ===== design/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: one bit per physical frame in a word-wide bitmap memory. After reset
// the block clears all MAX_FRAMES/32 bitmap words (rounded up; 1024 by default) in turn,
// with req_stall high; configuration writes are taken during that pass. Mark used, mark free
// and test read the memory word, then modify and write it back (test only reads the bit). A
// find examines bitmap words in turn, up to usable_count/32 of them, where the usable count
// is frame_count capped at MAX_FRAMES, and stops at the first word with a clear bit. A request
// naming a frame at or above the usable count, or a find with fewer than 32 frames, is
// answered without a memory read. One request is in flight at a time; a finished word
// may wait in the output register while the next request is taken.
module frame_bitmap_allocator #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fba_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fba_pkg::rsp_type               rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fba_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fba_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import fba_pkg::*;

   localparam int WORDS = (MAX_FRAMES + 31) / 32;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [FRAME_COUNT_W-1:0] frame_count;
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [WORD_BITS-1:0]     wr_data, rd_data;

   fba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .frame_count (frame_count)
   );

   fba_bitmap_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fba_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORDS      (WORDS),
      .AW         (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .frame_count (frame_count),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

endmodule

// ===== design/fba_bitmap_ram.sv =====
// Bitmap store: one write port and one registered read port, one word wide.
// Depends on fba_pkg for the word width.
module fba_bitmap_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [fba_pkg::WORD_BITS-1:0]   wr_data,
   input  logic                            rd_en,
   input  logic [AW-1:0]                   rd_addr,
   output logic [fba_pkg::WORD_BITS-1:0]   rd_data
);
   import fba_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fba_csr.sv =====
// Configuration register file holding the frame count.
// Depends on fba_pkg for addresses, widths and the reset value.
module fba_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fba_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fba_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fba_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [fba_pkg::FRAME_COUNT_W-1:0] frame_count
);
   import fba_pkg::*;

   logic [FRAME_COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic                     wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready && (paddr == CSR_FRAME_COUNT_ADDR);

   always_comb begin
      frame_count_in = frame_count_ff;
      if (wr_hit) begin
         frame_count_in = pwdata[FRAME_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_FRAME_COUNT_ADDR) begin
         prdata = CSR_DATA_W'(frame_count_ff);
      end
   end

   assign frame_count = frame_count_ff;

endmodule

// ===== design/fba_ctrl.sv =====
// Request sequencer: clearing pass, read-modify-write, word scan for find,
// and the output register. Depends on fba_pkg; drives the bitmap store ports.
module fba_ctrl #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT,
   parameter int WORDS      = (MAX_FRAMES + 31) / 32,
   parameter int AW         = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fba_pkg::FRAME_COUNT_W-1:0] frame_count,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fba_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fba_pkg::rsp_type                  rsp_payload,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic [fba_pkg::WORD_BITS-1:0]     wr_data,
   output logic                              rd_en,
   output logic [AW-1:0]                     rd_addr,
   input  logic [fba_pkg::WORD_BITS-1:0]     rd_data
);
   import fba_pkg::*;

   localparam int LW = ($clog2(MAX_FRAMES + 1) > FRAME_COUNT_W) ?
                       $clog2(MAX_FRAMES + 1) : FRAME_COUNT_W;
   localparam int SW = LW - 5;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RMW   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [SW-1:0]        scan_ff, scan_in;
   op_type               op_ff, op_in;
   logic [4:0]           bit_ff, bit_in;
   logic [AW-1:0]        word_ff, word_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [LW-1:0]        count_ext, limit, frame_ext;
   logic [SW-1:0]        words, scan_next;
   logic                 accept, slot_free, finish;
   rsp_type              res_cur, res_zero;
   logic [WORD_BITS-1:0] mask;

   assign count_ext = LW'(frame_count);
   assign limit     = (count_ext < LW'(MAX_FRAMES)) ? count_ext : LW'(MAX_FRAMES);
   assign words     = limit[LW-1:5];
   assign frame_ext = {{(LW - FRAME_NUMBER_W){1'b0}}, req_payload.frame_number};
   assign scan_next = scan_ff + 1'b1;
   assign mask      = WORD_BITS'(1) << bit_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign res_zero  = '{frame_used: 1'b0, found_frame: '0, none_free: 1'b0, bad_frame: 1'b0};

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      scan_in  = scan_ff;
      op_in    = op_ff;
      bit_in   = bit_ff;
      word_in  = word_ff;
      res_in   = res_ff;
      res_cur  = res_zero;
      finish   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = word_ff;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = word_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_payload.operation;
               bit_in  = req_payload.frame_number[4:0];
               word_in = frame_ext[AW+4:5];
               if (req_payload.operation == OP_FIND) begin
                  if (words == '0) begin
                     res_in             = res_zero;
                     res_in.found_frame = frame_count;
                     res_in.none_free   = 1'b1;
                     state_in           = ST_HOLD;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end else if (frame_ext >= limit) begin
                  res_in           = res_zero;
                  res_in.bad_frame = 1'b1;
                  state_in         = ST_HOLD;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = frame_ext[AW+4:5];
                  state_in = ST_RMW;
               end
            end
         end
         ST_RMW: begin
            finish = 1'b1;
            case (op_ff)
               OP_MARK_USED: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | mask;
               end
               OP_MARK_FREE: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~mask;
               end
               OP_TEST: begin
                  res_cur.frame_used = rd_data[bit_ff];
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // The next word is fetched while this one is examined.
            if (rd_data != '1) begin
               finish              = 1'b1;
               res_cur.found_frame = FRAME_COUNT_W'({scan_ff, first_zero(rd_data)});
            end else if (scan_next < words) begin
               rd_en   = 1'b1;
               rd_addr = scan_next[AW-1:0];
               scan_in = scan_next;
            end else begin
               finish              = 1'b1;
               res_cur.found_frame = frame_count;
               res_cur.none_free   = 1'b1;
            end
         end
         ST_HOLD: begin
            finish  = 1'b1;
            res_cur = res_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         if (slot_free) begin
            state_in = ST_IDLE;
         end else begin
            res_in   = res_cur;
            state_in = ST_HOLD;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (finish && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      op_ff   <= op_in;
      bit_ff  <= bit_in;
      word_ff <= word_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/fba_checker.sv =====
// Port-level checks for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg for the payload types.
module fba_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fba_pkg::rsp_type rsp_payload
);
   import fba_pkg::*;

   // The bitmap clearing pass holds off requests straight after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during the clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result word changed");

   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_frame |->
         !rsp_payload.frame_used && !rsp_payload.none_free && rsp_payload.found_frame == '0)
      else $error("bad frame result carries other flags");

   a_used_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_used |->
         !rsp_payload.none_free && rsp_payload.found_frame == '0)
      else $error("test result carries find fields");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/sv/frame_allocator_checker.sv =====
// Response checker for the frame bitmap allocator: keeps its own copy of the usage bitmap
// and of the frame count, predicts every response and compares it with the block's output.
// Depends on fba_pkg for the request and response words and the operation codes.
module frame_allocator_checker #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  fba_pkg::req_type               req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  fba_pkg::rsp_type               rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fba_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [fba_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             failures,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import fba_pkg::*;

   localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;

   logic [WORD_BITS-1:0]     usage_map [BITMAP_WORDS];
   logic [FRAME_COUNT_W-1:0] frame_count_q;
   rsp_type                  expected_rsp_q [$];

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endfunction

   // Applies one request to the mirrored bitmap and returns the response it should give.
   function automatic rsp_type allocate_response(input req_type r);
      rsp_type     p;
      int unsigned limit;
      int unsigned words;
      int unsigned fn;
      bit          hit;
      p     = '0;
      hit   = 1'b0;
      limit = (frame_count_q < MAX_FRAMES) ? frame_count_q : MAX_FRAMES;
      fn    = r.frame_number;
      if (r.operation == OP_FIND) begin
         // Only whole words below the usable count are searched.
         words = limit / WORD_BITS;
         for (int w = 0; w < words && !hit; w++) begin
            if (usage_map[w] != '1) begin
               for (int b = 0; b < WORD_BITS && !hit; b++) begin
                  if (!usage_map[w][b]) begin
                     p.found_frame = FRAME_COUNT_W'(w * WORD_BITS + b);
                     hit = 1'b1;
                  end
               end
            end
         end
         if (!hit) begin
            p.found_frame = frame_count_q;
            p.none_free   = 1'b1;
         end
      end else if (fn >= limit) begin
         p.bad_frame = 1'b1;
      end else begin
         case (r.operation)
            OP_MARK_USED: usage_map[fn / WORD_BITS][fn % WORD_BITS] = 1'b1;
            OP_MARK_FREE: usage_map[fn / WORD_BITS][fn % WORD_BITS] = 1'b0;
            default:      p.frame_used = usage_map[fn / WORD_BITS][fn % WORD_BITS];
         endcase
      end
      return p;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type exp;
      rsp_type got;
      if (reset) begin
         foreach (usage_map[i]) usage_map[i] = '0;
         frame_count_q = FRAME_COUNT_RESET;
         expected_rsp_q.delete();
         failures = 0;
      end else begin
         if (psel && penable && pready && paddr == CSR_FRAME_COUNT_ADDR) begin
            if (pwrite) begin
               frame_count_q = pwdata[FRAME_COUNT_W-1:0];
            end else if (prdata[FRAME_COUNT_W-1:0] !== frame_count_q) begin
               note_failure($sformatf("frame count read back as %0d, expected %0d",
                                      prdata[FRAME_COUNT_W-1:0], frame_count_q));
            end
         end
         // Responses are checked before this edge's request is predicted, so the oldest
         // expectation is always the one at the front.
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_rsp_q.size() == 0) begin
               note_failure($sformatf("response word with nothing outstanding: %p", got));
            end else begin
               exp = expected_rsp_q.pop_front();
               if (got.frame_used !== exp.frame_used || got.found_frame !== exp.found_frame ||
                   got.none_free !== exp.none_free || got.bad_frame !== exp.bad_frame) begin
                  note_failure($sformatf({"response mismatch: expected used=%0b found=%0d ",
                     "none=%0b bad=%0b, got used=%0b found=%0d none=%0b bad=%0b"},
                     exp.frame_used, exp.found_frame, exp.none_free, exp.bad_frame,
                     got.frame_used, got.found_frame, got.none_free, got.bad_frame));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(allocate_response(req_payload));
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the frame bitmap allocator testbench: clock, reset, request and response traffic,
// frame count writes over the register port, and the final verdict.
// Depends on fba_pkg, frame_bitmap_allocator and frame_allocator_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fba_pkg::*;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    failures;
   int                    pending;

   int send_idle_max    = 18;
   int reply_idle_max   = 18;
   int reply_hold       = 0;
   int current_count    = 32768;
   int items_sent       = 0;
   int settings_written = 0;

   frame_bitmap_allocator DUT (.*);

   frame_allocator_checker response_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after the word was taken.
   task automatic send_request(input op_type op, input logic [FRAME_NUMBER_W-1:0] frame);
      int gap;
      gap = $urandom_range(send_idle_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, frame_number: frame};
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      items_sent++;
   endtask

   // The task always waits for a falling edge, so the next raise of valid falls in a later step.
   task automatic hold_requests_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame_count(input logic [FRAME_COUNT_W-1:0] count);
      hold_requests_until_drained();
      // The upper half of the data bus lies outside the register and carries noise.
      csr_access(1'b1, CSR_FRAME_COUNT_ADDR, {16'($urandom()), count});
      csr_access(1'b0, CSR_FRAME_COUNT_ADDR, '0);
      current_count = count;
      settings_written++;
   endtask

   // Mostly allocation-like traffic: a cursor marks frames in ascending order so that the
   // low words fill up and finds have to search further, mixed with frees, tests and finds.
   task automatic run_traffic_phase(input int n_items);
      int                        span;
      int                        cursor;
      int                        roll;
      op_type                    op;
      logic [FRAME_NUMBER_W-1:0] frame;
      span   = (current_count < 32760) ? current_count + 8 : 32767;
      cursor = 0;
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) begin
            hold_requests_until_drained();
         end
         roll  = $urandom_range(99, 0);
         frame = FRAME_NUMBER_W'($urandom_range(span, 0));
         if (roll < 30) begin
            op     = OP_MARK_USED;
            frame  = FRAME_NUMBER_W'(cursor);
            cursor = (cursor >= span) ? 0 : cursor + 1;
         end else if (roll < 40) begin
            op = OP_MARK_USED;
         end else if (roll < 55) begin
            op = OP_MARK_FREE;
         end else if (roll < 75) begin
            op = OP_TEST;
         end else begin
            op = OP_FIND;
         end
         if ($urandom_range(9, 0) == 0) begin
            frame = FRAME_NUMBER_W'($urandom());
         end
         send_request(op, frame);
      end
   endtask

   // Response side: a fresh hold-off is drawn before each word, or a long hold when asked.
   initial begin : reply_side
      int wait_cycles;
      forever begin
         if (reply_hold > 0) begin
            wait_cycles = reply_hold;
            reply_hold  = 0;
         end else begin
            wait_cycles = $urandom_range(reply_idle_max, 0);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int                        phase_counts [14] = '{32, 0, 64, 31, 100, 65535, 33, 1000,
                                                       40000, 96, 2048, 32767, 200, 32768};
      logic [FRAME_NUMBER_W-1:0] victim;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, CSR_FRAME_COUNT_ADDR, '0);

      // Directed words at the reset count: field extremes and alternating bit patterns.
      send_request(OP_FIND, '1);
      send_request(OP_MARK_USED, '0);
      send_request(OP_TEST, '0);
      send_request(OP_FIND, '0);
      send_request(OP_MARK_USED, '1);
      send_request(OP_TEST, '1);
      send_request(OP_MARK_FREE, '1);
      send_request(OP_TEST, '1);
      send_request(OP_TEST, 15'h2AAA);
      send_request(OP_MARK_USED, 15'h5555);
      send_request(OP_TEST, 15'h5555);
      send_request(OP_MARK_FREE, '0);
      // A partial last word can be written and tested; frames past the count are refused.
      set_frame_count(16'd40);
      send_request(OP_MARK_USED, 15'd39);
      send_request(OP_TEST, 15'd39);
      send_request(OP_TEST, 15'd40);
      send_request(OP_MARK_USED, 15'd40);
      send_request(OP_FIND, '0);
      set_frame_count(16'd0);
      send_request(OP_FIND, '0);
      send_request(OP_TEST, '0);
      // A count beyond capacity is clipped to the bitmap size.
      set_frame_count(16'hFFFF);
      send_request(OP_TEST, '1);
      send_request(OP_FIND, '0);
      // Fewer than 32 frames means there is no whole word to search.
      set_frame_count(16'd31);
      send_request(OP_FIND, '0);
      send_request(OP_MARK_USED, 15'd30);

      foreach (phase_counts[p]) begin
         set_frame_count(FRAME_COUNT_W'(phase_counts[p]));
         send_idle_max  = (p % 3 == 1) ? 0 : 18;
         reply_idle_max = (p % 4 == 2) ? 0 : 18;
         if (p == 4) begin
            reply_hold = 400;
         end
         run_traffic_phase(105);
      end

      // Fill the low frames so that the none-free report is seen, also with a partial last
      // word that the search never looks at.
      set_frame_count(16'd96);
      send_idle_max  = 0;
      reply_idle_max = 0;
      for (int f = 0; f < 96; f++) begin
         send_request(OP_MARK_USED, FRAME_NUMBER_W'(f));
      end
      send_idle_max  = 18;
      reply_idle_max = 18;
      send_request(OP_FIND, '0);
      set_frame_count(16'd127);
      send_request(OP_FIND, '0);
      set_frame_count(16'd96);
      victim = FRAME_NUMBER_W'($urandom_range(95, 0));
      send_request(OP_MARK_FREE, victim);
      send_request(OP_FIND, '0);
      send_request(OP_TEST, victim);
      send_request(OP_TEST, '1);

      hold_requests_until_drained();
      // A long find could still be under way if a stray response were coming.
      repeat (1100) @(negedge clock);
      $display("Sent %0d request words across %0d frame count settings (0 to 65535),",
               items_sent, settings_written);
      $display("from an empty bitmap through partial words to a fully used region.");
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         if (pending != 0) begin
            $display("%0d expected response words never arrived", pending);
         end
         $display("%0d mismatches in total", failures);
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #100ms;
      $display("Timed out with %0d response words outstanding", pending);
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/fba_pkg.sv
design/fba_bitmap_ram.sv
design/fba_csr.sv
design/fba_ctrl.sv
design/frame_bitmap_allocator.sv
design/fba_checker.sv
tb/sv/frame_allocator_checker.sv
tb/sv/testbench.sv
